FILE: src/ellipse_alpha_accumulate_macros.svh
// Assertion macros shared by the ellipse alpha accumulator.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef ELLIPSE_ALPHA_ACCUMULATE_MACROS_SVH
`define ELLIPSE_ALPHA_ACCUMULATE_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define EAA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define EAA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EAA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define EAA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: src/eaa_pkg.sv
package eaa_pkg;

  // Default tile edge length in pixels.
  localparam int DEF_TILE_SIZE = 64;

  // Value of the darkening step register after reset.
  localparam logic [7:0] ALPHA_INC_RESET = 8'd16;

  // Operation codes.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  center_x;
    logic [5:0]  center_y;
    logic [4:0]  semi_width;
    logic [4:0]  semi_height;
    logic [11:0] read_address;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       status;
    logic [7:0] alpha_value;
  } out_item_t;

  // Commands from the sequencer to the tile memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_zero;
  } mem_cmd_t;

endpackage

FILE: src/eaa_tile_mem.sv
module eaa_tile_mem #(
  parameter int TILE_SIZE = eaa_pkg::DEF_TILE_SIZE,
  localparam int Depth = TILE_SIZE * TILE_SIZE,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  eaa_pkg::mem_cmd_t cmd_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [7:0]       wr_data_i,
  output logic [7:0]       rd_data_o
);
  import eaa_pkg::*;

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/eaa_darken.sv
module eaa_darken (
  input  logic [7:0] alpha_i,
  input  logic [7:0] increase_i,
  output logic [7:0] alpha_o
);
  import eaa_pkg::*;

  logic [7:0]  step;
  logic [15:0] prod;
  logic [8:0]  sum;

  // The step halves for every sixteen levels of alpha already present.
  always_comb begin
    step    = increase_i >> alpha_i[7:4];
    prod    = 16'(step) * 16'(8'd255 - alpha_i);
    sum     = {1'b0, alpha_i} + {1'b0, prod[15:8]};
    alpha_o = sum[8] ? 8'd255 : sum[7:0];
  end

endmodule

FILE: src/eaa_seq.sv
`include "ellipse_alpha_accumulate_macros.svh"

module eaa_seq #(
  parameter int TILE_SIZE = eaa_pkg::DEF_TILE_SIZE,
  localparam int TilePixels = TILE_SIZE * TILE_SIZE,
  localparam int AW = $clog2(TilePixels),
  localparam int CW = $clog2(TILE_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eaa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eaa_pkg::out_item_t out_item_o,
  output eaa_pkg::mem_cmd_t  mem_cmd_o,
  output logic [AW-1:0]      rd_addr_o,
  output logic [AW-1:0]      wr_addr_o,
  input  logic [7:0]         rd_data_i
);
  import eaa_pkg::*;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_READ      = 4'd2;
  localparam logic [3:0] S_READ_DONE = 4'd3;
  localparam logic [3:0] S_SETUP     = 4'd4;
  localparam logic [3:0] S_SETUP2    = 4'd5;
  localparam logic [3:0] S_SEG       = 4'd6;
  localparam logic [3:0] S_Y1        = 4'd7;
  localparam logic [3:0] S_Y2        = 4'd8;
  localparam logic [3:0] S_L1        = 4'd9;
  localparam logic [3:0] S_L2        = 4'd10;
  localparam logic [3:0] S_L3        = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  localparam logic [1:0] PH_CENTRE = 2'd0;
  localparam logic [1:0] PH_UPPER  = 2'd1;
  localparam logic [1:0] PH_LOWER  = 2'd2;

  localparam logic [AW-1:0] LastPixel = AW'(TilePixels - 1);

  // Control state.
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_item_q, clr_item_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers.
  logic [5:0]    cx_q, cx_d, cy_q, cy_d;
  logic [4:0]    w_q, w_d, h_q, h_d, y_q, y_d;
  logic [9:0]    ww_q, ww_d, hh_q, hh_d, yy_q, yy_d;
  logic [19:0]   wh_q, wh_d, yyww_q, yyww_d, lhh_q, lhh_d;
  logic [10:0]   lsq_q, lsq_d;
  logic [5:0]    lim_q, lim_d, span_q, span_d, shrink_q, shrink_d;
  logic [CW-1:0] seg_col_q, seg_col_d, seg_end_q, seg_end_d, seg_row_q, seg_row_d;
  logic [1:0]    phase_q, phase_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d, rd_addr_q, rd_addr_d;
  out_item_t     res_q, res_d, out_q, out_d;

  logic [AW-1:0] seg_addr;
  logic [7:0]    lim_start;
  logic [20:0]   lhs;

  // Linear address of the pixel under the segment walker.
  assign seg_addr = AW'(seg_row_q) * AW'(TILE_SIZE) + AW'(seg_col_q);

  // Next search start: previous span less previous shrink plus one, floored at zero.
  assign lim_start = {2'b00, span_q} - {2'b00, shrink_q} + 8'd1;
  assign lhs = 21'(lhh_q) + 21'(yyww_q);

  // Sequencer: clear sweep, pixel reads, and the scanline fill of a draw.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_item_d  = clr_item_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    cx_d        = cx_q;
    cy_d        = cy_q;
    w_d         = w_q;
    h_d         = h_q;
    y_d         = y_q;
    ww_d        = ww_q;
    hh_d        = hh_q;
    yy_d        = yy_q;
    wh_d        = wh_q;
    yyww_d      = yyww_q;
    lhh_d       = lhh_q;
    lsq_d       = lsq_q;
    lim_d       = lim_q;
    span_d      = span_q;
    shrink_d    = shrink_q;
    seg_col_d   = seg_col_q;
    seg_end_d   = seg_end_q;
    seg_row_d   = seg_row_q;
    phase_d     = phase_q;
    pend_addr_d = pend_addr_q;
    rd_addr_d   = rd_addr_q;
    res_d       = res_q;
    out_d       = out_q;

    mem_cmd_o       = '0;
    mem_cmd_o.wr_en = pend_q;
    rd_addr_o       = seg_addr;
    wr_addr_o       = pend_addr_q;
    in_ready_o      = (state_q == S_IDLE);

    case (state_q)
      S_CLEAR: begin
        mem_cmd_o.wr_en   = 1'b1;
        mem_cmd_o.wr_zero = 1'b1;
        wr_addr_o         = clr_cnt_q;
        clr_cnt_d         = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastPixel) begin
          clr_cnt_d  = '0;
          clr_item_d = 1'b0;
          res_d      = '0;
          state_d    = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          case (in_item_i.func)
            FUNC_CLEAR: begin
              clr_item_d = 1'b1;
              state_d    = S_CLEAR;
            end
            FUNC_DRAW: begin
              cx_d = in_item_i.center_x;
              cy_d = in_item_i.center_y;
              w_d  = in_item_i.semi_width;
              h_d  = in_item_i.semi_height;
              if (in_item_i.center_x >= 6'(in_item_i.semi_width) &&
                  in_item_i.center_y >= 6'(in_item_i.semi_height) &&
                  9'(in_item_i.center_x) + 9'(in_item_i.semi_width) < 9'(TILE_SIZE) &&
                  9'(in_item_i.center_y) + 9'(in_item_i.semi_height) < 9'(TILE_SIZE)) begin
                state_d = S_SETUP;
              end else begin
                res_d.status = 1'b1;
                state_d      = S_DONE;
              end
            end
            FUNC_READ: begin
              rd_addr_d = AW'(in_item_i.read_address);
              if (32'(in_item_i.read_address) < 32'(TilePixels)) begin
                state_d = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        mem_cmd_o.rd_en = 1'b1;
        rd_addr_o       = rd_addr_q;
        state_d         = S_READ_DONE;
      end
      S_READ_DONE: begin
        res_d.alpha_value = rd_data_i;
        state_d           = S_DONE;
      end
      S_SETUP: begin
        // Squares of the semi-axes; the centre row spans the full width.
        ww_d      = 10'(w_q) * 10'(w_q);
        hh_d      = 10'(h_q) * 10'(h_q);
        span_d    = {1'b0, w_q};
        shrink_d  = '0;
        y_d       = '0;
        seg_col_d = CW'(9'(cx_q) - 9'(w_q));
        seg_end_d = CW'(9'(cx_q) + 9'(w_q));
        seg_row_d = CW'(cy_q);
        phase_d   = PH_CENTRE;
        state_d   = S_SETUP2;
      end
      S_SETUP2: begin
        wh_d    = 20'(ww_q) * 20'(hh_q);
        state_d = S_SEG;
      end
      S_SEG: begin
        // Read one pixel; its write-back follows in the next cycle.
        mem_cmd_o.rd_en = 1'b1;
        pend_d          = 1'b1;
        pend_addr_d     = seg_addr;
        if (seg_col_q == seg_end_q) begin
          if (phase_q == PH_UPPER) begin
            seg_row_d = CW'(9'(cy_q) + 9'(y_q));
            seg_col_d = CW'(9'(cx_q) - 9'(span_q));
            phase_d   = PH_LOWER;
          end else if (y_q == h_q) begin
            state_d = S_DONE;
          end else begin
            y_d     = y_q + 1'b1;
            state_d = S_Y1;
          end
        end else begin
          seg_col_d = seg_col_q + 1'b1;
        end
      end
      S_Y1: begin
        yy_d    = 10'(y_q) * 10'(y_q);
        lim_d   = lim_start[7] ? 6'd0 : lim_start[5:0];
        state_d = S_Y2;
      end
      S_Y2: begin
        yyww_d  = 20'(yy_q) * 20'(ww_q);
        state_d = S_L1;
      end
      S_L1: begin
        lsq_d   = 11'(lim_q) * 11'(lim_q);
        state_d = S_L2;
      end
      S_L2: begin
        lhh_d   = 20'(lsq_q) * 20'(hh_q);
        state_d = S_L3;
      end
      S_L3: begin
        // Shrink the half-span while the point lies outside the ellipse.
        if (lim_q != 6'd0 && lhs > 21'(wh_q)) begin
          lim_d   = lim_q - 1'b1;
          state_d = S_L1;
        end else begin
          shrink_d  = span_q - lim_q;
          span_d    = lim_q;
          seg_col_d = CW'(9'(cx_q) - 9'(lim_q));
          seg_end_d = CW'(9'(cx_q) + 9'(lim_q));
          seg_row_d = CW'(9'(cy_q) - 9'(y_q));
          phase_d   = PH_UPPER;
          state_d   = S_SEG;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_item_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_item_q  <= clr_item_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    w_q         <= w_d;
    h_q         <= h_d;
    y_q         <= y_d;
    ww_q        <= ww_d;
    hh_q        <= hh_d;
    yy_q        <= yy_d;
    wh_q        <= wh_d;
    yyww_q      <= yyww_d;
    lhh_q       <= lhh_d;
    lsq_q       <= lsq_d;
    lim_q       <= lim_d;
    span_q      <= span_d;
    shrink_q    <= shrink_d;
    seg_col_q   <= seg_col_d;
    seg_end_q   <= seg_end_d;
    seg_row_q   <= seg_row_d;
    phase_q     <= phase_d;
    pend_addr_q <= pend_addr_d;
    rd_addr_q   <= rd_addr_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Pixels of one draw are all distinct, so a read never meets the pending write.
  `EAA_ASSERT_IMPL(a_rw_apart, clk_i, rst_ni, mem_cmd_o.rd_en && mem_cmd_o.wr_en, rd_addr_o != wr_addr_o, "read and write address the same pixel")
  `EAA_ASSERT_IMPL(a_lim_bound, clk_i, rst_ni, state_q == S_L3, lim_q <= ({1'b0, w_q} + 6'd1), "half-span search above semi-width plus one")
  `EAA_ASSERT_IMPL(a_seg_order, clk_i, rst_ni, state_q == S_SEG, seg_col_q <= seg_end_q, "segment walker passed its end column")
  `EAA_ASSERT_NEXT(a_wr_follows_rd, clk_i, rst_ni, state_q == S_SEG, mem_cmd_o.wr_en && !mem_cmd_o.wr_zero, "pixel read without write-back")

endmodule

FILE: src/ellipse_alpha_accumulate.sv
// Ellipse alpha accumulator: a TILE_SIZE by TILE_SIZE tile of 8-bit alpha values.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one item per operation:
// clear the tile, draw a filled ellipse, or read one pixel. Output channel
// (out_valid_o/out_ready_i, out_item_o) returns one item per operation: status is
// set for an ellipse that does not fit the tile, alpha_value carries the read pixel.
// cfg_we_i/cfg_wdata_i write the base darkening step at any edge; its reset value is 16.
// Items are handled one at a time; the tile memory has one read and one write port.
// A read gives the registered memory data as its result; a clear zeroes every pixel.
// A draw sets up the squared semi-axes, fills the centre row pixel by pixel, then per
// row pair above and below the centre runs the half-span search and fills both rows;
// a rejected draw or an unused code goes straight to its result. The next item is
// accepted in the cycle after a result enters the output register.
// A draw's pixels are read and written back in a two-stage pipeline on the memory.
// After reset the block sweeps all TILE_SIZE*TILE_SIZE pixels of the tile to zero
// (4096 at the default size) and holds in_ready_o low meanwhile.
// A finished item waits in the output register while the receiver stalls; the
// block accepts the next item in that time and holds its result until the
// register is free.
module ellipse_alpha_accumulate #(
  parameter int TILE_SIZE = eaa_pkg::DEF_TILE_SIZE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eaa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eaa_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);
  import eaa_pkg::*;

  localparam int AW = $clog2(TILE_SIZE * TILE_SIZE);

  logic [7:0]    alpha_inc_q;
  mem_cmd_t      mem_cmd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_data, dark_alpha, wr_data;

  // Darkening step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_inc_q <= ALPHA_INC_RESET;
    end else if (cfg_we_i) begin
      alpha_inc_q <= cfg_wdata_i;
    end
  end

  eaa_seq #(
    .TILE_SIZE (TILE_SIZE)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .mem_cmd_o   (mem_cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .rd_data_i   (rd_data)
  );

  eaa_darken u_darken (
    .alpha_i    (rd_data),
    .increase_i (alpha_inc_q),
    .alpha_o    (dark_alpha)
  );

  // Clearing writes zero; a draw writes back the darkened pixel.
  assign wr_data = mem_cmd.wr_zero ? 8'd0 : dark_alpha;

  eaa_tile_mem #(
    .TILE_SIZE (TILE_SIZE)
  ) u_tile_mem (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule
